// ----- rtl/ssag_pkg.sv -----
package ssag_pkg;

  localparam int ADDR_BITS = 32;
  localparam int POS_W     = ADDR_BITS + 1;
  localparam int CNT_W     = 16;
  localparam int ERR_W     = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int TECH_W    = 2;
  localparam int STATUS_W  = 2;

  localparam logic [CNT_W-1:0] CHUNK_MAX = 16'hFFFF;

  // Output queue geometry.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 88;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_LBA = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TECHNIQUE = 3'd4;

  localparam logic [TECH_W-1:0] TECH_SEQ  = 2'd1;
  localparam logic [TECH_W-1:0] TECH_STAG = 2'd2;
  localparam logic [TECH_W-1:0] TECH_BOTH = 2'd3;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DONE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_GOOD  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNSUP = 2'd2;

  localparam logic KIND_CMD    = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [ADDR_BITS-1:0] block_addr;
    logic [CNT_W-1:0]     block_count;
    logic                 pass_kind;
    logic                 pass_failed;
    logic [ERR_W-1:0]     error_count;
    logic                 last;
  } res_t;

  // Up to two result words produced by one input word; v1 implies v0.
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } push_t;

  typedef struct packed {
    logic                 ok;
    logic [ADDR_BITS-1:0] len;
  } seg_t;

  function automatic logic [CNT_W-1:0] chunk_of(input logic [ADDR_BITS-1:0] left);
    logic [CNT_W-1:0] c;
    c = (left > ADDR_BITS'(CHUNK_MAX)) ? CHUNK_MAX : left[CNT_W-1:0];
    return c;
  endfunction

  // A segment starting at pos exists if pos is below capacity; its length
  // is the distance to capacity, clipped to the segment size.
  function automatic seg_t seg_load(input logic [POS_W-1:0]     pos,
                                    input logic [ADDR_BITS-1:0] cap,
                                    input logic [ADDR_BITS-1:0] seg_sz);
    seg_t             s;
    logic [POS_W-1:0] rem;
    rem   = {1'b0, cap} - pos;
    s.ok  = pos < {1'b0, cap};
    s.len = (rem[ADDR_BITS-1:0] > seg_sz) ? seg_sz : rem[ADDR_BITS-1:0];
    return s;
  endfunction

  function automatic res_t make_cmd(input logic [POS_W-1:0]     addr,
                                    input logic [ADDR_BITS-1:0] left,
                                    input logic                 pk);
    res_t r;
    r.kind        = KIND_CMD;
    r.block_addr  = addr[ADDR_BITS-1:0];
    r.block_count = chunk_of(left);
    r.pass_kind   = pk;
    r.pass_failed = 1'b0;
    r.error_count = '0;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic res_t make_report(input logic             pk,
                                       input logic             failed,
                                       input logic [ERR_W-1:0] errs,
                                       input logic             last);
    res_t r;
    r.kind        = KIND_REPORT;
    r.block_addr  = '0;
    r.block_count = '0;
    r.pass_kind   = pk;
    r.pass_failed = failed;
    r.error_count = errs;
    r.last        = last;
    return r;
  endfunction

endpackage

// ----- rtl/staggered_scrub_address_generator_top.sv -----
// Patrol verify sequencer. A start word (in_tuser low) begins a scrub and a
// completion word (in_tuser high, status in in_tdata) reports the outcome of
// the last issued verify; each accepted word yields the next verify command
// or, at the end of a pass, a pass report, and at a pass boundary in the
// combined technique a report and then the staggered pass's first command or
// report. Starts while busy and completions while idle produce nothing. All
// work for a word is done in the cycle it is accepted, and its results land
// in a four-word output queue, so one word is taken per cycle while the
// queue has room for two results; the sustained rate is one word per cycle
// when each word gives one result and the sink keeps out_tready high, and a
// word that gives two results leaves one more word in the queue. Write the
// configuration registers only while no scrub is in progress.
module staggered_scrub_address_generator_top
  import ssag_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // status[1:0], zero fill
  input  logic                   in_tuser,   // cmd
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // block_addr[31:0], block_count[47:32],
                                             // pass_kind[48], pass_failed[49],
                                             // error_count[81:50], zero fill
  output logic                   out_tuser,  // kind
  output logic                   out_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  logic [ADDR_BITS-1:0] capacity_r, segment_r, region_r, start_lba_r;
  logic [TECH_W-1:0]    technique_r;
  logic                 step_en;
  push_t                push;
  res_t                 res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= '0;
      segment_r   <= ADDR_BITS'(4096);
      region_r    <= ADDR_BITS'(262144);
      start_lba_r <= '0;
      technique_r <= TECH_BOTH;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_CAPACITY:  capacity_r  <= cfg_wdata[ADDR_BITS-1:0];
        CFG_SEGMENT:   segment_r   <= cfg_wdata[ADDR_BITS-1:0];
        CFG_REGION:    region_r    <= cfg_wdata[ADDR_BITS-1:0];
        CFG_START_LBA: start_lba_r <= cfg_wdata[ADDR_BITS-1:0];
        CFG_TECHNIQUE: technique_r <= cfg_wdata[TECH_W-1:0];
        default: ;
      endcase
    end
  end

  assign step_en = in_tvalid && in_tready;

  ssag_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .cmd       (in_tuser),
    .status    (in_tdata[STATUS_W-1:0]),
    .capacity  (capacity_r),
    .segment   (segment_r),
    .region    (region_r),
    .start_lba (start_lba_r),
    .technique (technique_r),
    .push      (push)
  );

  ssag_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res)
  );

  assign out_tdata = {6'b0, res.error_count, res.pass_failed, res.pass_kind,
                      res.block_count, res.block_addr};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

// ----- rtl/ssag_seq.sv -----
module ssag_seq
  import ssag_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  logic                 cmd,
  input  logic [STATUS_W-1:0]  status,
  input  logic [ADDR_BITS-1:0] capacity,
  input  logic [ADDR_BITS-1:0] segment,
  input  logic [ADDR_BITS-1:0] region,
  input  logic [ADDR_BITS-1:0] start_lba,
  input  logic [TECH_W-1:0]    technique,
  output push_t                push
);

  logic                 busy_r, busy_nxt;
  logic                 pass_now_r, pass_now_nxt;
  logic [POS_W-1:0]     seg_start_r, seg_start_nxt;
  logic [ADDR_BITS-1:0] seg_left_r, seg_left_nxt;
  logic [POS_W-1:0]     chunk_addr_r, chunk_addr_nxt;
  logic [POS_W-1:0]     stag_off_r, stag_off_nxt;
  logic                 fail_unsup_r, fail_unsup_nxt;
  logic [ERR_W-1:0]     err_cnt_r, err_cnt_nxt;

  logic [ADDR_BITS-1:0] seg_sz, reg_sz;
  logic                 want_seq, want_stag;
  logic [POS_W-1:0]     first_pos, pos_seq_next, pos_reg_next, pos_off_next;
  seg_t                 ld_first, ld_zero, ld_seq, ld_reg, ld_off;
  logic [CNT_W-1:0]     chunk_done;
  logic [ADDR_BITS-1:0] left_after;
  logic [POS_W-1:0]     chunk_after;
  logic [ERR_W-1:0]     err_inc;

  logic                 found, report, failed, more;
  logic [POS_W-1:0]     new_pos;
  logic [ADDR_BITS-1:0] new_len;

  // Zero sizes act as one block.
  assign seg_sz    = (segment == '0) ? ADDR_BITS'(1) : segment;
  assign reg_sz    = (region == '0) ? ADDR_BITS'(1) : region;
  assign want_seq  = (technique != TECH_STAG);
  assign want_stag = (technique != TECH_SEQ);

  // All candidate segment positions are evaluated in parallel.
  assign first_pos    = want_seq ? {1'b0, start_lba} : '0;
  assign pos_seq_next = seg_start_r + {1'b0, seg_sz};
  assign pos_reg_next = seg_start_r + {1'b0, reg_sz};
  assign pos_off_next = stag_off_r + {1'b0, seg_sz};

  assign ld_first = seg_load(first_pos, capacity, seg_sz);
  assign ld_zero  = seg_load('0, capacity, seg_sz);
  assign ld_seq   = seg_load(pos_seq_next, capacity, seg_sz);
  assign ld_reg   = seg_load(pos_reg_next, capacity, seg_sz);
  assign ld_off   = seg_load(pos_off_next, capacity, seg_sz);

  assign chunk_done  = chunk_of(seg_left_r);
  assign left_after  = seg_left_r - ADDR_BITS'(chunk_done);
  assign chunk_after = chunk_addr_r + POS_W'(chunk_done);
  assign err_inc     = (err_cnt_r != '1) ? err_cnt_r + ERR_W'(1) : err_cnt_r;

  always_comb begin
    busy_nxt       = busy_r;
    pass_now_nxt   = pass_now_r;
    seg_start_nxt  = seg_start_r;
    seg_left_nxt   = seg_left_r;
    chunk_addr_nxt = chunk_addr_r;
    stag_off_nxt   = stag_off_r;
    fail_unsup_nxt = fail_unsup_r;
    err_cnt_nxt    = err_cnt_r;
    push           = '0;
    found          = 1'b0;
    report         = 1'b0;
    failed         = 1'b0;
    more           = 1'b0;
    new_pos        = '0;
    new_len        = '0;

    if (step_en) begin
      if (cmd == CMD_START) begin
        if (!busy_r) begin
          busy_nxt     = 1'b1;
          pass_now_nxt = !want_seq;
          err_cnt_nxt  = '0;
          stag_off_nxt = '0;
          found        = ld_first.ok;
          report       = !ld_first.ok;
          new_pos      = first_pos;
          new_len      = ld_first.len;
        end
      end else if (busy_r) begin
        if (status != ST_GOOD) begin
          err_cnt_nxt    = err_inc;
          fail_unsup_nxt = (status == ST_UNSUP);
        end
        seg_left_nxt   = left_after;
        chunk_addr_nxt = chunk_after;
        if (left_after != '0) begin
          push.v0 = 1'b1;
          push.r0 = make_cmd(chunk_after, left_after, pass_now_r);
        end else if (fail_unsup_nxt) begin
          // Unsupported verify: the pass is abandoned at the segment end.
          failed = 1'b1;
          report = 1'b1;
        end else if (!pass_now_r) begin
          found   = ld_seq.ok;
          report  = !ld_seq.ok;
          new_pos = pos_seq_next;
          new_len = ld_seq.len;
        end else if (pos_reg_next < {1'b0, capacity}) begin
          found   = 1'b1;
          new_pos = pos_reg_next;
          new_len = ld_reg.len;
        end else begin
          // Wrapped past the last region: move to the next segment offset.
          stag_off_nxt = pos_off_next;
          if (pos_off_next >= {1'b0, reg_sz}) begin
            report = 1'b1;
          end else begin
            found   = ld_off.ok;
            report  = !ld_off.ok;
            new_pos = pos_off_next;
            new_len = ld_off.len;
          end
        end
      end
    end

    if (found) begin
      seg_start_nxt  = new_pos;
      chunk_addr_nxt = new_pos;
      seg_left_nxt   = new_len;
      fail_unsup_nxt = 1'b0;
      push.v0        = 1'b1;
      push.r0        = make_cmd(new_pos, new_len, pass_now_nxt);
    end

    if (report) begin
      more    = !pass_now_nxt && want_stag;
      push.v0 = 1'b1;
      push.r0 = make_report(pass_now_nxt, failed, err_cnt_nxt, !more);
      if (!more) begin
        busy_nxt = 1'b0;
      end else begin
        // The staggered pass follows directly and starts at block zero.
        pass_now_nxt = 1'b1;
        err_cnt_nxt  = '0;
        stag_off_nxt = '0;
        push.v1      = 1'b1;
        if (ld_zero.ok) begin
          seg_start_nxt  = '0;
          chunk_addr_nxt = '0;
          seg_left_nxt   = ld_zero.len;
          fail_unsup_nxt = 1'b0;
          push.r1        = make_cmd('0, ld_zero.len, 1'b1);
        end else begin
          push.r1  = make_report(1'b1, 1'b0, '0, 1'b1);
          busy_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      pass_now_r   <= 1'b0;
      seg_start_r  <= '0;
      seg_left_r   <= '0;
      chunk_addr_r <= '0;
      stag_off_r   <= '0;
      fail_unsup_r <= 1'b0;
      err_cnt_r    <= '0;
    end else begin
      busy_r       <= busy_nxt;
      pass_now_r   <= pass_now_nxt;
      seg_start_r  <= seg_start_nxt;
      seg_left_r   <= seg_left_nxt;
      chunk_addr_r <= chunk_addr_nxt;
      stag_off_r   <= stag_off_nxt;
      fail_unsup_r <= fail_unsup_nxt;
      err_cnt_r    <= err_cnt_nxt;
    end
  end

endmodule

// ----- rtl/ssag_outq.sv -----
module ssag_outq
  import ssag_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_data
);

  res_t               q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               pop;
  logic [Q_PTR_W-1:0] wr_ptr_1;

  // Room for two words is needed since one input word may yield two.
  assign room      = (count_r <= Q_CNT_W'(Q_DEPTH - 2));
  assign out_valid = (count_r != '0);
  assign out_data  = q_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_1  = wr_ptr_r + Q_PTR_W'(1);

  assign wr_ptr_nxt = wr_ptr_r + Q_PTR_W'(push.v0) + Q_PTR_W'(push.v1);
  assign rd_ptr_nxt = rd_ptr_r + Q_PTR_W'(pop);
  assign count_nxt  = count_r + Q_CNT_W'(push.v0) + Q_CNT_W'(push.v1) - Q_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.v0) begin
      q_r[wr_ptr_r] <= push.r0;
    end
    if (push.v1) begin
      q_r[wr_ptr_1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- tb/staggered_scrub_address_generator_top_tb.sv -----
`timescale 1ns / 100ps

module staggered_scrub_address_generator_top_tb;
  import ssag_pkg::*;

  // Completion statuses without a name in the package.
  localparam logic [STATUS_W-1:0] ST_FAIL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OTHER = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;

  staggered_scrub_address_generator_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  int   idle_pct  = 0;
  int   stall_pct = 0;
  int   bad_words = 0;
  bit   big_cfg   = 1'b0;
  res_t scrub_words_q[$];

  // Sequencer state as the testbench sees it.
  logic [ADDR_BITS-1:0] cap_m, segsz_m, region_m, lba_m;
  logic [TECH_W-1:0]    tech_m;
  logic                 busy_m, stag_m, unsup_m;
  logic [POS_W-1:0]     seg_start_m, chunk_m, offset_m;
  logic [ADDR_BITS-1:0] left_m;
  logic [ERR_W-1:0]     errs_m;

  always @(posedge clk) begin
    out_tready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic logic [POS_W-1:0] seg_span();
    return (segsz_m == '0) ? POS_W'(1) : {1'b0, segsz_m};
  endfunction

  function automatic logic [POS_W-1:0] region_span();
    return (region_m == '0) ? POS_W'(1) : {1'b0, region_m};
  endfunction

  function automatic logic [CNT_W-1:0] chunk_len();
    return (left_m > ADDR_BITS'(CHUNK_MAX)) ? CHUNK_MAX : left_m[CNT_W-1:0];
  endfunction

  function automatic bit open_segment(logic [POS_W-1:0] pos);
    logic [POS_W-1:0] len;
    if (pos >= {1'b0, cap_m}) return 1'b0;
    len = {1'b0, cap_m} - pos;
    if (len > seg_span()) len = seg_span();
    seg_start_m = pos;
    chunk_m     = pos;
    left_m      = len[ADDR_BITS-1:0];
    unsup_m     = 1'b0;
    return 1'b1;
  endfunction

  function automatic bit open_pass(bit stag);
    stag_m   = stag;
    errs_m   = '0;
    offset_m = '0;
    return open_segment(stag ? '0 : {1'b0, lba_m});
  endfunction

  // Staggered order: same offset in every region, then the next offset.
  function automatic bit advance_segment();
    logic [POS_W-1:0] nxt;
    if (!stag_m) return open_segment(seg_start_m + seg_span());
    nxt = seg_start_m + region_span();
    if (nxt < {1'b0, cap_m}) return open_segment(nxt);
    offset_m = offset_m + seg_span();
    if (offset_m >= region_span()) return 1'b0;
    return open_segment(offset_m);
  endfunction

  function automatic void push_command();
    res_t r;
    r.kind        = KIND_CMD;
    r.block_addr  = chunk_m[ADDR_BITS-1:0];
    r.block_count = chunk_len();
    r.pass_kind   = stag_m;
    r.pass_failed = 1'b0;
    r.error_count = '0;
    r.last        = 1'b0;
    scrub_words_q.push_back(r);
  endfunction

  function automatic void push_report(bit failed, bit final_one);
    res_t r;
    r.kind        = KIND_REPORT;
    r.block_addr  = '0;
    r.block_count = '0;
    r.pass_kind   = stag_m;
    r.pass_failed = failed;
    r.error_count = errs_m;
    r.last        = final_one;
    scrub_words_q.push_back(r);
  endfunction

  function automatic void scrub_advance(logic cmd, logic [STATUS_W-1:0] st);
    bit               found, failed, more, ended;
    logic [CNT_W-1:0] done;
    failed = 1'b0;
    if (cmd == CMD_START) begin
      if (busy_m) return;
      busy_m = 1'b1;
      found  = open_pass(tech_m == TECH_STAG);
    end else begin
      if (!busy_m) return;
      if (st != ST_GOOD) begin
        if (errs_m != '1) errs_m = errs_m + ERR_W'(1);
        unsup_m = (st == ST_UNSUP);
      end
      done   = chunk_len();
      left_m = left_m - ADDR_BITS'(done);
      chunk_m = chunk_m + POS_W'(done);
      if (left_m != '0) begin
        push_command();
        return;
      end
      if (unsup_m) begin
        failed = 1'b1;
        found  = 1'b0;
      end else begin
        found = advance_segment();
      end
    end
    // A pass that ends may hand over to the staggered pass in the same word.
    ended = !found;
    while (ended) begin
      more = !stag_m && (tech_m != TECH_SEQ);
      push_report(failed, !more);
      if (!more) begin
        busy_m = 1'b0;
        return;
      end
      failed = 1'b0;
      ended  = !open_pass(1'b1);
    end
    push_command();
  endfunction

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_CAPACITY:  cap_m    = val;
      CFG_SEGMENT:   segsz_m  = val;
      CFG_REGION:    region_m = val;
      CFG_START_LBA: lba_m    = val;
      CFG_TECHNIQUE: tech_m   = val[TECH_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] cap, logic [31:0] seg, logic [31:0] rgn,
                            logic [31:0] lba, logic [31:0] tech);
    write_cfg(CFG_CAPACITY, cap);
    write_cfg(CFG_SEGMENT, seg);
    write_cfg(CFG_REGION, rgn);
    write_cfg(CFG_START_LBA, lba);
    write_cfg(CFG_TECHNIQUE, tech);
    cfg_we <= 1'b0;
  endtask

  task automatic send_word(logic cmd, logic [STATUS_W-1:0] st);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_TDATA_W-STATUS_W){1'b0}}, st};
    do @(posedge clk); while (!in_tready);
    scrub_advance(cmd, st);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  task automatic wait_results(int extra_cycles);
    in_tvalid <= 1'b0;
    while (scrub_words_q.size() != 0) @(posedge clk);
    repeat (extra_cycles) @(posedge clk);
  endtask

  function automatic logic [STATUS_W-1:0] pick_status();
    int r;
    r = $urandom_range(0, 99);
    if (big_cfg) begin
      if (r < 30) return ST_UNSUP;
      if (r < 40) return ST_FAIL;
      if (r < 45) return ST_OTHER;
    end else begin
      if (r < 5)  return ST_UNSUP;
      if (r < 13) return ST_FAIL;
      if (r < 16) return ST_OTHER;
    end
    return ST_GOOD;
  endfunction

  // Small devices keep a scrub short; big ones end through aborts.
  task automatic pick_config(bit big);
    logic [31:0] cap, seg, rgn, lba, tv;
    big_cfg = big;
    if (big) begin
      cap = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom;
      seg = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 64)
                                        : $urandom_range(60000, 300000);
      rgn = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom;
      lba = ($urandom_range(0, 1) == 0) ? cap - $urandom_range(0, 200000) : $urandom;
    end else begin
      cap = $urandom_range(0, 120);
      seg = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 40);
      rgn = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 100);
      lba = $urandom_range(0, cap + 10);
    end
    tv = $urandom;
    tv[TECH_W-1:0] = TECH_W'($urandom_range(0, 3));
    set_config(cap, seg, rgn, lba, tv);
  endtask

  task automatic test_defaults();
    send_word(CMD_DONE, ST_GOOD);
    send_word(CMD_START, ST_OTHER);
    wait_results(4);
    set_config(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, {30'd0, TECH_SEQ});
    send_word(CMD_START, ST_GOOD);
    wait_results(4);
  endtask

  task automatic test_both_passes();
    set_config(32'd10, 32'd4, 32'd8, 32'd6, {30'd0, TECH_BOTH});
    send_word(CMD_START, ST_GOOD);
    send_word(CMD_START, ST_GOOD);
    send_word(CMD_DONE, ST_FAIL);
    send_word(CMD_DONE, ST_OTHER);
    send_word(CMD_DONE, ST_UNSUP);
    send_word(CMD_DONE, ST_GOOD);
    wait_results(4);
  endtask

  task automatic test_large_chunks();
    set_config(32'hFFFF_FFFF, 32'd200000, 32'hFFFF_FFFF, 32'hFFFF_FFFF - 32'd70000,
               {30'd0, TECH_SEQ});
    send_word(CMD_START, ST_GOOD);
    send_word(CMD_DONE, ST_GOOD);
    send_word(CMD_DONE, ST_FAIL);
    wait_results(4);
    // Two chunks of exactly the largest size.
    set_config(32'hFFFF_FFFF, 32'd131070, 32'hFFFF_FFFF, 32'd0, {30'd0, TECH_STAG});
    send_word(CMD_START, ST_GOOD);
    send_word(CMD_DONE, ST_FAIL);
    send_word(CMD_DONE, ST_UNSUP);
    wait_results(4);
  endtask

  task automatic test_zero_sizes();
    set_config(32'd3, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
    send_word(CMD_START, ST_GOOD);
    send_word(CMD_DONE, ST_GOOD);
    send_word(CMD_DONE, ST_OTHER);
    send_word(CMD_DONE, ST_GOOD);
    wait_results(4);
  endtask

  task automatic test_random(int sender_idle, int sink_stall, int target);
    int counted;
    idle_pct  = sender_idle;
    stall_pct = sink_stall;
    counted   = 0;
    pick_config($urandom_range(0, 4) == 0);
    while (counted < target) begin
      if (!busy_m) begin
        if ($urandom_range(0, 3) == 0) begin
          wait_results(4);
          pick_config($urandom_range(0, 4) == 0);
        end
        if ($urandom_range(0, 9) == 0) begin
          send_word(CMD_DONE, STATUS_W'($urandom_range(0, 3)));
        end else begin
          send_word(CMD_START, STATUS_W'($urandom_range(0, 3)));
          counted++;
        end
      end else if ($urandom_range(0, 14) == 0) begin
        send_word(CMD_START, STATUS_W'($urandom_range(0, 3)));
      end else begin
        // Let the output side run dry in the middle of a scrub now and then.
        if (counted % 97 == 50) wait_results(1);
        send_word(CMD_DONE, pick_status());
        counted++;
      end
    end
    while (busy_m) send_word(CMD_DONE, ST_UNSUP);
    wait_results(4);
  endtask

  always begin : check_words
    res_t seen, want;
    @(posedge clk);
    if (rst_n && out_tvalid && out_tready) begin
      seen.kind        = out_tuser;
      seen.block_addr  = out_tdata[31:0];
      seen.block_count = out_tdata[47:32];
      seen.pass_kind   = out_tdata[48];
      seen.pass_failed = out_tdata[49];
      seen.error_count = out_tdata[81:50];
      seen.last        = out_tlast;
      @(negedge clk);
      if (scrub_words_q.size() == 0) begin
        bad_words++;
        $display("%0t: unexpected word: expected none, actual kind=%0d addr=%h count=%0d",
                 $time, seen.kind, seen.block_addr, seen.block_count);
      end else begin
        want = scrub_words_q.pop_front();
        if (seen !== want) begin
          bad_words++;
          $display("%0t: word mismatch", $time);
          $display("  expected kind=%0d addr=%h count=%0d pass=%0d failed=%0d err=%0d last=%0d",
                   want.kind, want.block_addr, want.block_count, want.pass_kind,
                   want.pass_failed, want.error_count, want.last);
          $display("  actual   kind=%0d addr=%h count=%0d pass=%0d failed=%0d err=%0d last=%0d",
                   seen.kind, seen.block_addr, seen.block_count, seen.pass_kind,
                   seen.pass_failed, seen.error_count, seen.last);
        end
      end
    end
  end

  initial begin
    cap_m       = '0;
    segsz_m     = 32'd4096;
    region_m    = 32'd262144;
    lba_m       = '0;
    tech_m      = TECH_BOTH;
    busy_m      = 1'b0;
    stag_m      = 1'b0;
    unsup_m     = 1'b0;
    seg_start_m = '0;
    chunk_m     = '0;
    offset_m    = '0;
    left_m      = '0;
    errs_m      = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_both_passes();
    test_large_chunks();
    test_zero_sizes();
    test_random(0, 0, 400);
    test_random(51, 0, 400);
    test_random(0, 51, 400);
    test_random(38, 38, 400);
    wait_results(10);
    if (bad_words == 0 && scrub_words_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout with %0d words still expected", $time, scrub_words_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
